// File: src/dht_pkg.sv
// ----------------------------------------------------------------------------
// dht_pkg
// Shared types and codes for the double hashing table.
// ----------------------------------------------------------------------------
package dht_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic [1:0] MARK_EMPTY   = 2'd0;
  localparam logic [1:0] MARK_USED    = 2'd1;
  localparam logic [1:0] MARK_DELETED = 2'd2;

  // magnitude width of the hash sums fed to the remainder unit
  localparam int MOD_W   = 17;
  // remainder unit phase counter: estimate, subtract, correct
  localparam int MODCNT_W = 2;

  typedef struct packed {
    logic       load;
    logic       clr_step;
    logic       mod_start_h1;
    logic       mod_start_h2;
    logic       mod_step;
    logic       save_h1;
    logic       save_h2;
    logic       probe_next;
    logic       wr_insert;
    logic       wr_remove;
    logic       res_set;
    logic [1:0] res_status;
    logic       res_take_val;
    logic       res_load;
  } dht_cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       mod_last;
    logic       op_insert;
    logic       op_find;
    logic       op_remove;
    logic [1:0] mark;
    logic       key_eq;
    logic       probe_last;
  } dht_stat_t;

endpackage

// File: src/dht_if.sv
// ----------------------------------------------------------------------------
// dht_if
// Request and response channels of the double hashing table.
// ----------------------------------------------------------------------------
interface dht_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [63:0]        key_head;
  logic [15:0]        key_tail;
  logic [3:0]         key_length;
  logic signed [31:0] item_value;

  modport source (output valid, opcode, key_head, key_tail, key_length, item_value,
                  input ready);
  modport sink (input valid, opcode, key_head, key_tail, key_length, item_value,
                output ready);
endinterface

interface dht_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [9:0]         slot_index;
  logic signed [31:0] found_value;

  modport source (output valid, status, slot_index, found_value, input ready);
  modport sink (input valid, status, slot_index, found_value, output ready);
endinterface

// File: src/dht_ctrl.sv
// ----------------------------------------------------------------------------
// dht_ctrl
// Sequencer: clearing pass, hashing, probe walk and response handoff.
// ----------------------------------------------------------------------------
module dht_ctrl
  import dht_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dht_stat_t stat,
  output dht_cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_MOD1  = 4'd3;
  localparam logic [3:0] S_H1    = 4'd4;
  localparam logic [3:0] S_MOD2  = 4'd5;
  localparam logic [3:0] S_H2    = 4'd6;
  localparam logic [3:0] S_RD    = 4'd7;
  localparam logic [3:0] S_CHK   = 4'd8;
  localparam logic [3:0] S_RESP  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.res_status = ST_NOT_FOUND;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        cmd.mod_start_h1 = 1'b1;
        state_nxt        = S_MOD1;
      end
      S_MOD1: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) state_nxt = S_H1;
      end
      S_H1: begin
        cmd.save_h1      = 1'b1;
        cmd.mod_start_h2 = 1'b1;
        state_nxt        = S_MOD2;
      end
      S_MOD2: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) state_nxt = S_H2;
      end
      S_H2: begin
        cmd.save_h2 = 1'b1;
        if (stat.op_insert || stat.op_find || stat.op_remove) begin
          state_nxt = S_RD;
        end else begin
          cmd.res_set = 1'b1;
          state_nxt   = S_RESP;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.op_insert) begin
          if (stat.mark != MARK_USED) begin
            cmd.wr_insert  = 1'b1;
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_OK;
            state_nxt      = S_RESP;
          end else if (stat.probe_last) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_FULL;
            state_nxt      = S_RESP;
          end else begin
            cmd.probe_next = 1'b1;
            state_nxt      = S_RD;
          end
        end else begin
          if (stat.mark == MARK_EMPTY) begin
            cmd.res_set = 1'b1;
            state_nxt   = S_RESP;
          end else if (stat.mark == MARK_USED && stat.key_eq) begin
            cmd.res_set      = 1'b1;
            cmd.res_status   = ST_OK;
            cmd.res_take_val = stat.op_find;
            cmd.wr_remove    = stat.op_remove;
            state_nxt        = S_RESP;
          end else if (stat.probe_last) begin
            cmd.res_set = 1'b1;
            state_nxt   = S_RESP;
          end else begin
            cmd.probe_next = 1'b1;
            state_nxt      = S_RD;
          end
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: src/dht_dp.sv
// ----------------------------------------------------------------------------
// dht_dp
// Datapath: key capture, hash sums, remainder unit, slot stores, result regs.
// ----------------------------------------------------------------------------
module dht_dp
  import dht_pkg::*;
#(
  parameter int TABLE_SIZE    = 1021,
  parameter int MAX_KEY_CHARS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dht_cmd_t           cmd,
  output dht_stat_t          stat,
  input  logic [1:0]         in_opcode,
  input  logic [63:0]        in_key_head,
  input  logic [15:0]        in_key_tail,
  input  logic [3:0]         in_key_length,
  input  logic signed [31:0] in_item_value,
  output logic [1:0]         out_status,
  output logic [9:0]         out_slot_index,
  output logic signed [31:0] out_found_value
);

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int CHR_W  = 8 * MAX_KEY_CHARS;
  localparam int KEY_W  = CHR_W + 4;
  localparam int PRD_W  = 2 * MOD_W;
  // floor(2^MOD_W / TABLE_SIZE); quotient estimate is low by at most one
  localparam int RECIP  = (1 << MOD_W) / TABLE_SIZE;

  logic [1:0]         op_r;
  logic [KEY_W-1:0]   key_r;
  logic [31:0]        val_r;

  logic [3:0]         len_c;
  logic [79:0]        all_chars;
  logic [CHR_W-1:0]   chars_m;

  logic [11:0]        h1_sum;
  logic signed [17:0] s2_sum;
  logic [MOD_W-1:0]   rem_r;
  logic [MOD_W-1:0]   q_r;
  logic [MODCNT_W-1:0] bit_r;
  logic               neg_r;
  logic [PRD_W-1:0]   q_prod, qt_prod;
  logic [IDX_W-1:0]   rem_idx, h2_fix;

  logic [IDX_W-1:0]   h1_r, h2_r, idx_r, cnt_r, clr_r;
  logic [IDX_W:0]     idx_sum;

  logic [1:0]         mark_mem [TABLE_SIZE];
  logic [KEY_W-1:0]   key_mem  [TABLE_SIZE];
  logic [31:0]        data_mem [TABLE_SIZE];
  logic [1:0]         rd_mark;
  logic [KEY_W-1:0]   rd_key;
  logic [31:0]        rd_data;

  logic               mark_we;
  logic [IDX_W-1:0]   mark_wa;
  logic [1:0]         mark_wd;

  logic [1:0]         pend_status_r;
  logic [9:0]         pend_slot_r;
  logic [31:0]        pend_val_r;
  logic [1:0]         out_status_r;
  logic [9:0]         out_slot_r;
  logic [31:0]        out_val_r;

  // clamp length and blank characters past it
  always_comb begin
    len_c     = (in_key_length > 4'(MAX_KEY_CHARS)) ? 4'(MAX_KEY_CHARS) : in_key_length;
    all_chars = {in_key_tail, in_key_head};
    for (int k = 0; k < MAX_KEY_CHARS; k++) begin
      chars_m[8*k +: 8] = (k < int'(len_c)) ? all_chars[8*k +: 8] : 8'd0;
    end
  end

  // hash sums over the captured key; blanked characters add nothing to h1
  always_comb begin
    h1_sum = '0;
    for (int k = 0; k < MAX_KEY_CHARS; k++) begin
      h1_sum = h1_sum + 12'(key_r[8*k +: 8]);
    end
    s2_sum = '0;
    if (key_r[KEY_W-1 -: 4] > 4'd0)
      s2_sum = s2_sum + ($signed({10'd0, key_r[7:0]}) - 18'sd96);
    if (key_r[KEY_W-1 -: 4] > 4'd1)
      s2_sum = s2_sum + ($signed({10'd0, key_r[15:8]}) - 18'sd96) * 18'sd27;
    if (key_r[KEY_W-1 -: 4] > 4'd2)
      s2_sum = s2_sum + ($signed({10'd0, key_r[23:16]}) - 18'sd96) * 18'sd729;
  end

  assign q_prod  = PRD_W'(rem_r) * PRD_W'(MOD_W'(RECIP));
  assign qt_prod = PRD_W'(q_r) * PRD_W'(MOD_W'(TABLE_SIZE));
  assign rem_idx = IDX_W'(rem_r);

  always_comb begin
    h2_fix = rem_idx;
    if (neg_r && rem_idx != '0) h2_fix = IDX_W'(TABLE_SIZE) - rem_idx;
    if (h2_fix == '0) h2_fix = IDX_W'(1);
  end

  assign idx_sum = {1'b0, idx_r} + {1'b0, h2_r};

  always_comb begin
    mark_we = 1'b0;
    mark_wa = idx_r;
    mark_wd = MARK_EMPTY;
    if (cmd.clr_step) begin
      mark_we = 1'b1;
      mark_wa = clr_r;
    end else if (cmd.wr_insert) begin
      mark_we = 1'b1;
      mark_wd = MARK_USED;
    end else if (cmd.wr_remove) begin
      mark_we = 1'b1;
      mark_wd = MARK_DELETED;
    end
  end

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    if (cmd.wr_insert) begin
      key_mem[idx_r]  <= key_r;
      data_mem[idx_r] <= val_r;
    end
    rd_mark <= mark_mem[idx_r];
    rd_key  <= key_mem[idx_r];
    rd_data <= data_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      key_r <= {len_c, chars_m};
      val_r <= in_item_value;
    end
    if (cmd.mod_start_h1) begin
      rem_r <= MOD_W'(h1_sum);
      neg_r <= 1'b0;
      bit_r <= MODCNT_W'(2);
    end else if (cmd.mod_start_h2) begin
      rem_r <= s2_sum[17] ? MOD_W'(-s2_sum) : MOD_W'(s2_sum);
      neg_r <= s2_sum[17];
      bit_r <= MODCNT_W'(2);
    end else if (cmd.mod_step) begin
      // reciprocal estimate, subtract, then one conditional correction
      case (bit_r)
        MODCNT_W'(2): q_r <= q_prod[PRD_W-1:MOD_W];
        MODCNT_W'(1): rem_r <= rem_r - qt_prod[MOD_W-1:0];
        default: begin
          if (rem_r >= MOD_W'(TABLE_SIZE)) rem_r <= rem_r - MOD_W'(TABLE_SIZE);
        end
      endcase
      bit_r <= bit_r - MODCNT_W'(1);
    end
    if (cmd.save_h1) h1_r <= rem_idx;
    if (cmd.save_h2) begin
      h2_r  <= h2_fix;
      idx_r <= h1_r;
      cnt_r <= '0;
    end else if (cmd.probe_next) begin
      idx_r <= (idx_sum >= (IDX_W+1)'(TABLE_SIZE))
               ? IDX_W'(idx_sum - (IDX_W+1)'(TABLE_SIZE)) : IDX_W'(idx_sum);
      cnt_r <= cnt_r + IDX_W'(1);
    end
    if (cmd.res_set) begin
      pend_status_r <= cmd.res_status;
      pend_slot_r   <= (cmd.res_status == ST_OK) ? 10'(idx_r) : 10'd0;
      pend_val_r    <= cmd.res_take_val ? rd_data : 32'd0;
    end
    if (cmd.res_load) begin
      out_status_r <= pend_status_r;
      out_slot_r   <= pend_slot_r;
      out_val_r    <= pend_val_r;
    end
  end

  always_comb begin
    stat            = '0;
    stat.clr_done   = (clr_r == IDX_W'(TABLE_SIZE - 1));
    stat.mod_last   = (bit_r == '0);
    stat.op_insert  = (op_r == OP_INSERT);
    stat.op_find    = (op_r == OP_FIND);
    stat.op_remove  = (op_r == OP_REMOVE);
    stat.mark       = rd_mark;
    stat.key_eq     = (rd_key == key_r);
    stat.probe_last = (cnt_r == IDX_W'(TABLE_SIZE - 1));
  end

  assign out_status      = out_status_r;
  assign out_slot_index  = out_slot_r;
  assign out_found_value = $signed(out_val_r);

endmodule

// File: src/double_hash_table.sv
// ----------------------------------------------------------------------------
// double_hash_table
// Open-addressing key/value table with double hashing: insert, find, remove.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot marks to empty, one slot per cycle,
// with in_chan.ready low. One request is handled at a time. Hashing runs
// both remainders through one reciprocal-multiply unit, each through the
// estimate, subtract and correct steps; each probe then reads the registered
// slot memory and checks the slot. An unused opcode gets its response
// without probing. The next request can be taken from the same cycle in which
// the response word appears; the response register lets that happen while a
// response is still waiting to be taken.
module double_hash_table
  import dht_pkg::*;
#(
  parameter int TABLE_SIZE    = 1021,
  parameter int MAX_KEY_CHARS = 10
) (
  input logic      clk,
  input logic      rst_n,
  dht_in_if.sink   in_chan,
  dht_out_if.source out_chan
);

  dht_cmd_t  cmd;
  dht_stat_t stat;

  dht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dht_dp #(
    .TABLE_SIZE    (TABLE_SIZE),
    .MAX_KEY_CHARS (MAX_KEY_CHARS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_opcode       (in_chan.opcode),
    .in_key_head     (in_chan.key_head),
    .in_key_tail     (in_chan.key_tail),
    .in_key_length   (in_chan.key_length),
    .in_item_value   (in_chan.item_value),
    .out_status      (out_chan.status),
    .out_slot_index  (out_chan.slot_index),
    .out_found_value (out_chan.found_value)
  );

endmodule

// File: src/dht_checker.sv
// ----------------------------------------------------------------------------
// dht_checker
// Port-level checks for the double hashing table, bound to the top level.
// ----------------------------------------------------------------------------
module dht_checker
  import dht_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [9:0]  slot_index,
  input logic [31:0] found_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("response word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(status) && $stable(found_value))
    else $error("response word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status == ST_OK || status == ST_NOT_FOUND || status == ST_FULL))
    else $error("unknown status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_OK |-> slot_index == 10'd0 && found_value == 32'd0)
    else $error("failed request carries slot or value");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

endmodule

bind double_hash_table dht_checker u_dht_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .status      (out_chan.status),
  .slot_index  (out_chan.slot_index),
  .found_value (out_chan.found_value)
);
